// ----- hw/rtl/spq_pkg.sv -----
package spq_pkg;

  typedef enum logic [2:0] {
    K_ENQ    = 3'd0,
    K_MARK   = 3'd1,
    K_COMMIT = 3'd2,
    K_TICK   = 3'd3,
    K_FETCH  = 3'd4,
    K_SENT   = 3'd5,
    K_RESET  = 3'd6,
    K_NOP    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOPEND  = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD    = 3'd0,
    CELL_LOAD    = 3'd1,
    CELL_MARK    = 3'd2,
    CELL_ROT     = 3'd3,
    CELL_SHIFT   = 3'd4,
    CELL_COMPACT = 3'd5,
    CELL_DEC     = 3'd6
  } cell_op_t;

  // Widths cover the largest supported queue depth (64).
  localparam int POS_W = 6;
  localparam int CNT_W = 7;

  typedef struct packed {
    logic [31:0] tag;
    logic [7:0]  slot;
    logic [11:0] off;
    logic [7:0]  rep;
    logic        eoq;
    logic        del;
  } entry_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/slot_parity_tx_queue_scheduler_top.sv -----
// Enqueue, mark delete, engine reset, NOP, tick with a message pending, and fetch with a message
//   pending or with no tick seen are handled in idle; the result strobe follows the next cycle.
// Tick/fetch scheduling and mark sent rotate the cell ring once in S_SCAN, then finish in S_FIN.
// Commit deletions removes one marked entry per cycle in S_COMPACT until none is left.
// One transaction at a time (busy high while working); the receiver cannot stall.
// Reset (rst_n low, synchronous): queue empty, nothing pending, max_entries = 10.
module slot_parity_tx_queue_scheduler_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_msg_tag,
  input  logic        in_end_of_qso,
  input  logic [7:0]  in_slot_id,
  input  logic [11:0] in_offset_hz,
  input  logic [7:0]  in_repeat_count,
  input  logic [3:0]  in_entry_index,
  input  logic [31:0] in_slot_index,
  input  logic        in_slot_parity,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic        out_has_entry,
  output logic [31:0] out_tag,
  output logic [7:0]  out_slot_id,
  output logic [11:0] out_offset_hz,
  output logic [7:0]  out_repeat_count,
  output logic        out_end_of_qso,
  output logic [4:0]  out_queue_count,
  output logic        out_pending_flag
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int W  = (CW > 5) ? CW : 5;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_SCAN    = 4'b0010,
    S_FIN     = 4'b0100,
    S_COMPACT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // latched transaction
  logic [2:0]  kind_r, kind_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [7:0]  slot_r, slot_nxt;
  logic [11:0] off_r, off_nxt;
  logic [31:0] sidx_r, sidx_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [4:0]    max_r, max_nxt;

  // pending message
  logic            pend_valid_r, pend_valid_nxt;
  spq_pkg::entry_t pend_entry_r, pend_entry_nxt;
  logic [IW-1:0]   pend_pos_r, pend_pos_nxt;
  logic            pend_ok_r, pend_ok_nxt;

  // last sent and last tick
  logic [31:0] last_slot_r, last_slot_nxt;
  logic        last_par_r, last_par_nxt;
  logic        last_ok_r, last_ok_nxt;
  logic [31:0] sched_slot_r, sched_slot_nxt;
  logic        sched_par_r, sched_par_nxt;
  logic        sched_ok_r, sched_ok_nxt;

  // scan
  logic [IW-1:0]   step_r, step_nxt;
  logic            found_r, found_nxt;
  logic [IW-1:0]   best_pos_r, best_pos_nxt;
  spq_pkg::entry_t best_r, best_nxt;
  logic            mfound_r, mfound_nxt;
  logic [IW-1:0]   mpos_r, mpos_nxt;
  logic [7:0]      mrep_r, mrep_nxt;
  logic            mdel_r, mdel_nxt;
  logic            pfound_r, pfound_nxt;
  logic [7:0]      prep_r, prep_nxt;
  logic            pdel_r, pdel_nxt;

  // result
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic        out_has_r, out_has_nxt;
  spq_pkg::entry_t out_entry_r, out_entry_nxt;
  logic [4:0]  out_count_r, out_count_nxt;
  logic        out_pend_r, out_pend_nxt;

  // cell ring
  spq_pkg::cell_ctrl_t cell_ctrl;
  spq_pkg::entry_t     new_entry;
  spq_pkg::entry_t     cell_q [QUEUE_DEPTH];
  logic                chain [QUEUE_DEPTH];

  assign new_entry = '{tag: in_msg_tag, slot: in_slot_id, off: in_offset_hz,
                       rep: in_repeat_count, eoq: in_end_of_qso, del: 1'b0};

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    spq_cell #(.IDX(g)) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .new_entry  (new_entry),
      .next_entry (cell_q[(g + 1) % QUEUE_DEPTH]),
      .chain_in   ((g == 0) ? 1'b0 : chain[(g == 0) ? 0 : g - 1]),
      .chain_out  (chain[g]),
      .entry      (cell_q[g])
    );
  end

  spq_pkg::entry_t cur;
  logic            in_range;
  logic            key_hit;
  logic            blank;
  logic            fin;
  logic [1:0]      fin_status;
  logic            fin_has;
  spq_pkg::entry_t fin_entry;
  logic            hit;
  logic [IW-1:0]   hit_pos;
  logic [7:0]      hit_rep;
  logic            hit_del;
  logic [7:0]      new_rep;
  logic            sched_now;

  assign cur      = cell_q[0];
  assign in_range = CW'(step_r) < count_r;
  assign key_hit  = (cur.tag == tag_r) && (cur.slot == slot_r) && (cur.off == off_r);
  assign blank    = last_ok_r && (last_par_r != sched_par_r) &&
                    (sched_slot_r == last_slot_r + 32'd1);

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    tag_nxt        = tag_r;
    slot_nxt       = slot_r;
    off_nxt        = off_r;
    sidx_nxt       = sidx_r;
    count_nxt      = count_r;
    max_nxt        = cfg_we ? cfg_wdata : max_r;
    pend_valid_nxt = pend_valid_r;
    pend_entry_nxt = pend_entry_r;
    pend_pos_nxt   = pend_pos_r;
    pend_ok_nxt    = pend_ok_r;
    last_slot_nxt  = last_slot_r;
    last_par_nxt   = last_par_r;
    last_ok_nxt    = last_ok_r;
    sched_slot_nxt = sched_slot_r;
    sched_par_nxt  = sched_par_r;
    sched_ok_nxt   = sched_ok_r;
    step_nxt       = step_r;
    found_nxt      = found_r;
    best_pos_nxt   = best_pos_r;
    best_nxt       = best_r;
    mfound_nxt     = mfound_r;
    mpos_nxt       = mpos_r;
    mrep_nxt       = mrep_r;
    mdel_nxt       = mdel_r;
    pfound_nxt     = pfound_r;
    prep_nxt       = prep_r;
    pdel_nxt       = pdel_r;
    cell_ctrl      = '{op: spq_pkg::CELL_HOLD, pos: '0,
                       count: spq_pkg::CNT_W'(count_r)};
    fin            = 1'b0;
    fin_status     = spq_pkg::ST_DONE;
    fin_has        = 1'b0;
    fin_entry      = '0;
    hit            = 1'b0;
    hit_pos        = '0;
    hit_rep        = '0;
    hit_del        = 1'b0;
    new_rep        = '0;
    sched_now      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt = in_kind;
          tag_nxt  = in_msg_tag;
          slot_nxt = in_slot_id;
          off_nxt  = in_offset_hz;
          sidx_nxt = in_slot_index;
          case (spq_pkg::kind_t'(in_kind))
            spq_pkg::K_ENQ: begin
              fin = 1'b1;
              if ((W'(count_r) >= W'(max_r)) || (count_r >= CW'(QUEUE_DEPTH))) begin
                fin_status = spq_pkg::ST_FULL;
              end else begin
                cell_ctrl.op = spq_pkg::CELL_LOAD;
                count_nxt    = count_r + CW'(1);
              end
            end
            spq_pkg::K_MARK: begin
              fin = 1'b1;
              if (W'(in_entry_index) < W'(count_r)) begin
                cell_ctrl.op  = spq_pkg::CELL_MARK;
                cell_ctrl.pos = spq_pkg::POS_W'(in_entry_index);
              end else begin
                fin_status = spq_pkg::ST_NOMATCH;
              end
            end
            spq_pkg::K_COMMIT: begin
              state_nxt = S_COMPACT;
            end
            spq_pkg::K_TICK: begin
              sched_slot_nxt = in_slot_index;
              sched_par_nxt  = in_slot_parity;
              sched_ok_nxt   = 1'b1;
              if (pend_valid_r) fin = 1'b1;
              else sched_now = 1'b1;
            end
            spq_pkg::K_FETCH: begin
              if (pend_valid_r) begin
                fin            = 1'b1;
                fin_has        = 1'b1;
                fin_entry      = pend_entry_r;
                pend_valid_nxt = 1'b0;
              end else if (sched_ok_r) begin
                sched_now = 1'b1;
              end else begin
                fin        = 1'b1;
                fin_status = spq_pkg::ST_NOPEND;
              end
            end
            spq_pkg::K_SENT: begin
              sched_now = 1'b1;
            end
            spq_pkg::K_RESET: begin
              fin            = 1'b1;
              pend_valid_nxt = 1'b0;
              pend_ok_nxt    = 1'b0;
              pend_pos_nxt   = '0;
              last_slot_nxt  = '0;
              last_par_nxt   = 1'b0;
              last_ok_nxt    = 1'b0;
              sched_slot_nxt = '0;
              sched_par_nxt  = 1'b0;
              sched_ok_nxt   = 1'b0;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
          if (sched_now) begin
            state_nxt  = S_SCAN;
            step_nxt   = '0;
            found_nxt  = 1'b0;
            mfound_nxt = 1'b0;
            pfound_nxt = 1'b0;
          end
        end
      end

      S_SCAN: begin
        // cell 0 holds queue position step_r this cycle
        cell_ctrl.op = spq_pkg::CELL_ROT;
        if (kind_r == spq_pkg::K_SENT) begin
          if (in_range && key_hit && !mfound_r) begin
            mfound_nxt = 1'b1;
            mpos_nxt   = step_r;
            mrep_nxt   = cur.rep;
            mdel_nxt   = cur.del;
          end
          if (in_range && key_hit && pend_ok_r && (step_r == pend_pos_r)) begin
            pfound_nxt = 1'b1;
            prep_nxt   = cur.rep;
            pdel_nxt   = cur.del;
          end
        end else begin
          // ascending scan: ">=" keeps the newest among equal priorities
          if (in_range && !cur.del && (cur.slot[0] == sched_par_r) &&
              (!found_r || (cur.eoq >= best_r.eoq))) begin
            found_nxt    = 1'b1;
            best_pos_nxt = step_r;
            best_nxt     = cur;
          end
        end
        step_nxt = step_r + IW'(1);
        if (step_r == IW'(QUEUE_DEPTH - 1)) state_nxt = S_FIN;
      end

      S_FIN: begin
        state_nxt = S_IDLE;
        fin       = 1'b1;
        if (kind_r == spq_pkg::K_SENT) begin
          last_slot_nxt  = sidx_r;
          last_par_nxt   = slot_r[0];
          last_ok_nxt    = 1'b1;
          pend_valid_nxt = 1'b0;
          pend_ok_nxt    = 1'b0;
          hit            = pfound_r | mfound_r;
          hit_pos        = pfound_r ? pend_pos_r : mpos_r;
          hit_rep        = pfound_r ? prep_r : mrep_r;
          hit_del        = pfound_r ? pdel_r : mdel_r;
          new_rep        = (hit_rep != 8'd0) ? hit_rep - 8'd1 : 8'd0;
          cell_ctrl.pos  = spq_pkg::POS_W'(hit_pos);
          if (!hit) begin
            fin_status = spq_pkg::ST_NOMATCH;
          end else if ((new_rep == 8'd0) || hit_del) begin
            cell_ctrl.op = spq_pkg::CELL_SHIFT;
            count_nxt    = count_r - CW'(1);
          end else begin
            cell_ctrl.op = spq_pkg::CELL_DEC;
          end
        end else begin
          if (found_r && !blank) begin
            pend_entry_nxt = best_r;
            pend_pos_nxt   = best_pos_r;
            pend_ok_nxt    = 1'b1;
            pend_valid_nxt = 1'b1;
          end
          if (kind_r == spq_pkg::K_FETCH) begin
            if (found_r && !blank) begin
              fin_has        = 1'b1;
              fin_entry      = best_r;
              pend_valid_nxt = 1'b0;
            end else begin
              fin_status = spq_pkg::ST_NOPEND;
            end
          end
        end
      end

      S_COMPACT: begin
        // drop the lowest marked entry each cycle until none is left
        cell_ctrl.op = spq_pkg::CELL_COMPACT;
        if (chain[QUEUE_DEPTH-1]) begin
          count_nxt = count_r - CW'(1);
        end else begin
          state_nxt = S_IDLE;
          fin       = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt  = fin;
    out_status_nxt = fin ? fin_status : out_status_r;
    out_has_nxt    = fin ? fin_has : out_has_r;
    out_entry_nxt  = fin ? fin_entry : out_entry_r;
    out_count_nxt  = fin ? 5'(count_nxt) : out_count_r;
    out_pend_nxt   = fin ? pend_valid_nxt : out_pend_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      max_r        <= 5'd10;
      pend_valid_r <= 1'b0;
      pend_ok_r    <= 1'b0;
      pend_pos_r   <= '0;
      last_slot_r  <= '0;
      last_par_r   <= 1'b0;
      last_ok_r    <= 1'b0;
      sched_slot_r <= '0;
      sched_par_r  <= 1'b0;
      sched_ok_r   <= 1'b0;
      step_r       <= '0;
      found_r      <= 1'b0;
      mfound_r     <= 1'b0;
      pfound_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      max_r        <= max_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_ok_r    <= pend_ok_nxt;
      pend_pos_r   <= pend_pos_nxt;
      last_slot_r  <= last_slot_nxt;
      last_par_r   <= last_par_nxt;
      last_ok_r    <= last_ok_nxt;
      sched_slot_r <= sched_slot_nxt;
      sched_par_r  <= sched_par_nxt;
      sched_ok_r   <= sched_ok_nxt;
      step_r       <= step_nxt;
      found_r      <= found_nxt;
      mfound_r     <= mfound_nxt;
      pfound_r     <= pfound_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    tag_r        <= tag_nxt;
    slot_r       <= slot_nxt;
    off_r        <= off_nxt;
    sidx_r       <= sidx_nxt;
    pend_entry_r <= pend_entry_nxt;
    best_pos_r   <= best_pos_nxt;
    best_r       <= best_nxt;
    mpos_r       <= mpos_nxt;
    mrep_r       <= mrep_nxt;
    mdel_r       <= mdel_nxt;
    prep_r       <= prep_nxt;
    pdel_r       <= pdel_nxt;
    out_status_r <= out_status_nxt;
    out_has_r    <= out_has_nxt;
    out_entry_r  <= out_entry_nxt;
    out_count_r  <= out_count_nxt;
    out_pend_r   <= out_pend_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_has_entry    = out_has_r;
  assign out_tag          = out_entry_r.tag;
  assign out_slot_id      = out_entry_r.slot;
  assign out_offset_hz    = out_entry_r.off;
  assign out_repeat_count = out_entry_r.rep;
  assign out_end_of_qso   = out_entry_r.eoq;
  assign out_queue_count  = out_count_r;
  assign out_pending_flag = out_pend_r;

endmodule

// ----- hw/rtl/spq_cell.sv -----
// One queue position. Takes its upper neighbor on rotate/shift/compact.
module spq_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::entry_t    new_entry,
  input  spq_pkg::entry_t    next_entry,
  input  logic               chain_in,
  output logic               chain_out,
  output spq_pkg::entry_t    entry
);

  spq_pkg::entry_t entry_r;
  logic occ;
  logic here;
  logic kill;

  assign occ  = spq_pkg::CNT_W'(IDX) < ctrl.count;
  assign here = spq_pkg::POS_W'(IDX) == ctrl.pos;

  always_comb begin
    case (ctrl.op)
      spq_pkg::CELL_SHIFT:   kill = here;
      spq_pkg::CELL_COMPACT: kill = entry_r.del && occ;
      default:               kill = 1'b0;
    endcase
  end

  // prefix-OR: every cell at or above the first removed one moves down
  assign chain_out = chain_in | kill;

  always_ff @(posedge clk) begin
    unique case (ctrl.op) inside
      spq_pkg::CELL_LOAD: begin
        if (spq_pkg::CNT_W'(IDX) == ctrl.count) entry_r <= new_entry;
      end
      spq_pkg::CELL_MARK: begin
        if (here) entry_r.del <= 1'b1;
      end
      spq_pkg::CELL_ROT: begin
        entry_r <= next_entry;
      end
      spq_pkg::CELL_SHIFT, spq_pkg::CELL_COMPACT: begin
        if (chain_out) entry_r <= next_entry;
      end
      spq_pkg::CELL_DEC: begin
        if (here && entry_r.rep != 8'd0) entry_r.rep <= entry_r.rep - 8'd1;
      end
      default: begin
        entry_r <= entry_r;
      end
    endcase
  end

  assign entry = entry_r;

endmodule
